FILE: hdl/wbd_pkg.sv
// ----------------------------------------------------------------------------
// wbd_pkg
// Types, constants and CORDIC helpers for the waypoint bearing/distance block.
// ----------------------------------------------------------------------------
package wbd_pkg;

  localparam int unsigned CordicStepsDef = 18;
  localparam int unsigned MaxSteps       = 32;
  localparam int unsigned Cw             = 42;
  localparam int unsigned PreBits        = 4;
  localparam int unsigned GainW          = 30;
  localparam logic [GainW-1:0] Gain      = 30'h26DD3B6A;
  localparam int unsigned HiW            = Cw - 16;
  localparam int unsigned PhW            = HiW + GainW;
  localparam int unsigned PlW            = 15 + GainW;
  localparam int unsigned SumW           = PhW + 1;
  localparam int unsigned MagW           = SumW - 19;

  localparam logic [31:0] AtanTab [MaxSteps] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef logic signed [Cw-1:0] cval_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
  } wbd_in_t;

  typedef struct packed {
    logic signed [15:0] yaw_angle;
    logic        [31:0] ground_speed;
    logic        [32:0] range_to_target;
    logic signed [15:0] heading_error;
  } wbd_res_t;

  typedef struct packed {
    cval_t       x;
    cval_t       y;
    logic [31:0] ang;
    logic        zero;
  } lane_t;

  typedef struct packed {
    lane_t yaw;
    lane_t spd;
    lane_t rng;
  } trio_t;

  function automatic lane_t cordic_init(cval_t x, cval_t y, logic zero);
    lane_t l;
    l.zero = zero;
    l.ang  = '0;
    l.x    = x <<< PreBits;
    l.y    = y <<< PreBits;
    if (x < 0) begin
      l.x   = -l.x;
      l.y   = -l.y;
      l.ang = 32'h80000000;
    end
    return l;
  endfunction

  function automatic lane_t cordic_step(lane_t l, int unsigned i);
    lane_t r;
    r = l;
    if (l.y > 0) begin
      r.x   = l.x + (l.y >>> i);
      r.y   = l.y - (l.x >>> i);
      r.ang = l.ang + AtanTab[i];
    end else begin
      r.x   = l.x - (l.y >>> i);
      r.y   = l.y + (l.x >>> i);
      r.ang = l.ang - AtanTab[i];
    end
    return r;
  endfunction

  function automatic logic [15:0] ang16(lane_t l);
    logic [31:0] s;
    s = l.ang + 32'h00008000;
    return l.zero ? 16'h0000 : s[31:16];
  endfunction

  function automatic logic [Cw-2:0] mag_in(lane_t l);
    return (l.zero || l.x <= 0) ? '0 : l.x[Cw-2:0];
  endfunction

endpackage

FILE: hdl/waypoint_bearing_distance.sv
// ----------------------------------------------------------------------------
// waypoint_bearing_distance
// Yaw, ground speed, range and heading error for one odometry item.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_i and pulse start; an item is taken at each clock edge with
//   start high and busy low. busy stays low, so an item may enter every
//   cycle. Three CORDIC vectoring lanes (yaw, velocity, target offset) run
//   side by side, one micro-rotation per register stage.
//   Pipeline: product stage, prerotation stage, min(CORDIC_STEPS, MaxSteps)
//   rotation stages, gain multiply stage, output stage.
//   Throughput: one item per cycle.
//   Each result shows on res_o for one cycle with done_o high; the
//   receiver must take it then.
//   Reset clears all valid bits; items in flight are dropped.
// ----------------------------------------------------------------------------
module waypoint_bearing_distance
  import wbd_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = CordicStepsDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  wbd_in_t  in_i,
  output logic     done_o,
  output wbd_res_t res_o
);

  localparam int unsigned N   = (CORDIC_STEPS > MaxSteps) ? MaxSteps : CORDIC_STEPS;
  localparam int unsigned Lat = N + 4;

  assign busy = 1'b0;

  logic               va_q;
  logic signed [31:0] p_wz_q, p_xy_q, p_yy_q, p_zz_q, p_xz_q, p_wy_q;
  logic signed [32:0] dx_q, dy_q;
  logic signed [31:0] vx_q, vy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else begin
      va_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    p_wz_q <= in_i.quat_w * in_i.quat_z;
    p_xy_q <= in_i.quat_x * in_i.quat_y;
    p_yy_q <= in_i.quat_y * in_i.quat_y;
    p_zz_q <= in_i.quat_z * in_i.quat_z;
    p_xz_q <= in_i.quat_x * in_i.quat_z;
    p_wy_q <= in_i.quat_w * in_i.quat_y;
    dx_q   <= {in_i.target_x[31], in_i.target_x} - {in_i.pos_x[31], in_i.pos_x};
    dy_q   <= {in_i.target_y[31], in_i.target_y} - {in_i.pos_y[31], in_i.pos_y};
    vx_q   <= in_i.vel_x;
    vy_q   <= in_i.vel_y;
  end

  logic signed [33:0] qa, qb, qg;
  logic               gimbal;
  trio_t              init_d;

  always_comb begin
    qa     = ({{2{p_wz_q[31]}}, p_wz_q} + {{2{p_xy_q[31]}}, p_xy_q}) <<< 1;
    qb     = 34'sd1073741824
           - (({{2{p_yy_q[31]}}, p_yy_q} + {{2{p_zz_q[31]}}, p_zz_q}) <<< 1);
    qg     = ({{2{p_xz_q[31]}}, p_xz_q} - {{2{p_wy_q[31]}}, p_wy_q}) <<< 1;
    gimbal = !(qg < 34'sd1073741824 && qg > -34'sd1073741824);
    init_d.yaw = cordic_init(cval_t'(qb), cval_t'(qa),
                             gimbal || (qa == '0 && qb == '0));
    init_d.spd = cordic_init(cval_t'(vx_q), cval_t'(vy_q),
                             vx_q == '0 && vy_q == '0);
    init_d.rng = cordic_init(cval_t'(dx_q), cval_t'(dy_q),
                             dx_q == '0 && dy_q == '0);
  end

  trio_t      cs_q [N+1];
  logic [N:0] cv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= '0;
    end else begin
      cv_q <= {cv_q[N-1:0], va_q};
    end
  end

  always_ff @(posedge clk_i) begin
    cs_q[0] <= init_d;
  end

  for (genvar k = 0; k < N; k++) begin : g_rot
    always_ff @(posedge clk_i) begin
      cs_q[k+1].yaw <= cordic_step(cs_q[k].yaw, k);
      cs_q[k+1].spd <= cordic_step(cs_q[k].spd, k);
      cs_q[k+1].rng <= cordic_step(cs_q[k].rng, k);
    end
  end

  logic              vm_q;
  logic [15:0]       yaw_q, brg_q;
  logic [Cw-2:0]     ms, mr;
  logic [PhW-1:0]    sph_q, rph_q;
  logic [PlW-1:0]    spl_q, rpl_q;

  assign ms = mag_in(cs_q[N].spd);
  assign mr = mag_in(cs_q[N].rng);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else begin
      vm_q <= cv_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    yaw_q <= ang16(cs_q[N].yaw);
    brg_q <= ang16(cs_q[N].rng);
    sph_q <= PhW'(ms[Cw-2:15]) * PhW'(Gain);
    rph_q <= PhW'(mr[Cw-2:15]) * PhW'(Gain);
    spl_q <= PlW'(ms[14:0]) * PlW'(Gain);
    rpl_q <= PlW'(mr[14:0]) * PlW'(Gain);
  end

  logic [SumW-1:0] ssum, rsum;
  logic [MagW-1:0] smag, rmag;
  wbd_res_t        res_d;

  always_comb begin
    ssum = SumW'(sph_q) + SumW'(spl_q[PlW-1:15]) + SumW'(1 << 18);
    rsum = SumW'(rph_q) + SumW'(rpl_q[PlW-1:15]) + SumW'(1 << 18);
    smag = ssum[SumW-1:19];
    rmag = rsum[SumW-1:19];
    res_d.yaw_angle       = yaw_q;
    res_d.ground_speed    = (smag[MagW-1:32] != '0) ? '1 : smag[31:0];
    res_d.range_to_target = (rmag[MagW-1:33] != '0) ? '1 : rmag[32:0];
    res_d.heading_error   = brg_q - yaw_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_o <= res_d;
  end

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##Lat done_o)
    else $error("item did not complete after fixed latency");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy && rst_ni, Lat))
    else $error("result without matching item");

  a_rest_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(in_i.vel_x == '0 && in_i.vel_y == '0, Lat)
    |-> res_o.ground_speed == '0)
    else $error("nonzero speed at rest");

endmodule
